// ===== design/mfts_pkg.sv =====
// ----------------------------------------------------------------------------
// Multirotor force and torque step: shared package
// Types, store addresses, item codes and the saturating helpers used by the
// step sequencer.
// ----------------------------------------------------------------------------
package mfts_pkg;

  typedef logic signed [63:0] s64_t;
  typedef logic signed [31:0] s32_t;

  // Item kinds carried in tuser.
  localparam logic [1:0] OP_SIGNAL = 2'd0;
  localparam logic [1:0] OP_STEP   = 2'd1;
  localparam logic [1:0] OP_LOAD   = 2'd2;

  // Coefficient store layout.
  localparam int COEF_N = 16;
  localparam int ALLOC_ROWS = 7;
  localparam logic [3:0] C_THR_S2  = 4'd0;
  localparam logic [3:0] C_THR_S1  = 4'd1;
  localparam logic [3:0] C_THR_S0  = 4'd2;
  localparam logic [3:0] C_DRG_S2  = 4'd3;
  localparam logic [3:0] C_DRG_S1  = 4'd4;
  localparam logic [3:0] C_DRG_S0  = 4'd5;
  localparam logic [3:0] C_TAU_UP  = 4'd6;
  localparam logic [3:0] C_TAU_DN  = 4'd7;
  localparam logic [3:0] C_MAX_THR = 4'd8;
  localparam logic [3:0] C_GE_Z4   = 4'd9;
  localparam logic [3:0] C_LIN_MU  = 4'd14;
  localparam logic [3:0] C_ANG_MU  = 4'd15;

  localparam logic [15:0] SIG_RESET = 16'd1000;
  localparam logic [3:0]  ROTOR_COUNT_RESET = 4'd4;

  localparam s64_t S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam s64_t S64_MIN = 64'sh8000_0000_0000_0000;
  localparam s64_t S32_MAX64 = 64'sd2147483647;
  localparam s64_t S32_MIN64 = -64'sd2147483648;

  // 64-bit add that saturates on overflow.
  function automatic s64_t sat_add(input s64_t a, input s64_t b);
    s64_t s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      s = a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

  // Saturate a 64-bit value to 32 bits.
  function automatic s32_t sat32(input s64_t x);
    s32_t r;
    if (x > S32_MAX64) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < S32_MIN64) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== design/multirotor_force_torque_step.sv =====
// ----------------------------------------------------------------------------
// Multirotor force and torque step
// Per time step, runs every active rotor through thrust and drag polynomials,
// a direction-dependent first-order lag and allocation, then adds drag and
// ground effect terms and emits body force and moment.
// ----------------------------------------------------------------------------
// Signal and load words are handled in the idle state; the block is ready again
// next cycle. A step word runs each active rotor in turn: every product goes
// through one shared 64x16 multiplier in 3 passes plus operand, saturate and
// update states, and the lag division, where needed, is bit-serial with a
// 32-bit quotient. One word is worked on at a time. Synchronous reset sets
// signals to SIG_RESET and clears thrust, drag, coefficients, allocation valid bits and the output valid.
// ----------------------------------------------------------------------------
module multirotor_force_torque_step #(
  parameter int MAX_ROTORS = 8
) (
  input  logic         clk,
  input  logic         rst,
  // Configuration: rotor_count
  input  logic         cfg_we,
  input  logic [3:0]   cfg_wdata,
  // Input words
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // index[6:0], value[54:7], time_step[85:55], altitude[117:86],
  // air_vel_x[149:118], air_vel_y[181:150], air_vel_z[213:182],
  // roll_rate[245:214], pitch_rate[277:246], yaw_rate[309:278], zero fill
  input  logic [311:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]   s_axis_tuser,
  // Result words
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // force_x[31:0], force_y[63:32], force_z[95:64], moment_l[127:96],
  // moment_m[159:128], moment_n[191:160]
  output logic [191:0] m_axis_tdata
);
  import mfts_pkg::*;

  localparam int RIW = (MAX_ROTORS > 1) ? $clog2(MAX_ROTORS) : 1;
  localparam int ALLOC_N = ALLOC_ROWS * MAX_ROTORS;
  localparam int AW = $clog2(ALLOC_N);
  localparam int LOAD_TOP = COEF_N + ALLOC_N;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_ROT    = 4'd2;
  localparam logic [3:0] S_OPND   = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_SAT    = 4'd5;
  localparam logic [3:0] S_POST   = 4'd6;
  localparam logic [3:0] S_DEN    = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_GEINIT = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  // Micro-step numbers: one product each.
  localparam logic [4:0] PC_T2     = 5'd0;
  localparam logic [4:0] PC_T2S    = 5'd1;
  localparam logic [4:0] PC_T1     = 5'd2;
  localparam logic [4:0] PC_D2     = 5'd3;
  localparam logic [4:0] PC_D2S    = 5'd4;
  localparam logic [4:0] PC_D1     = 5'd5;
  localparam logic [4:0] PC_LT_OLD = 5'd6;
  localparam logic [4:0] PC_LT_NEW = 5'd7;
  localparam logic [4:0] PC_LD_OLD = 5'd8;
  localparam logic [4:0] PC_LD_NEW = 5'd9;
  localparam logic [4:0] PC_AT0    = 5'd10;
  localparam logic [4:0] PC_AD0    = 5'd14;
  localparam logic [4:0] PC_AD2    = 5'd16;
  localparam logic [4:0] PC_GE0    = 5'd17;
  localparam logic [4:0] PC_GE3    = 5'd20;
  localparam logic [4:0] PC_DX     = 5'd21;
  localparam logic [4:0] PC_DY     = 5'd22;
  localparam logic [4:0] PC_DZ     = 5'd23;
  localparam logic [4:0] PC_DL     = 5'd24;
  localparam logic [4:0] PC_LAST   = 5'd26;

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  // Control state.
  logic [3:0]  state;
  logic [4:0]  pc;
  logic [4:0]  cnt;
  logic [4:0]  nrot;
  logic [1:0]  chunk;
  logic [4:0]  dcnt;
  logic [3:0]  rotor_count;

  // Rotor state and stores.
  logic [15:0] sig [MAX_ROTORS];
  s32_t        thr [MAX_ROTORS];
  s32_t        drg [MAX_ROTORS];
  logic signed [47:0] coef [COEF_N];
  logic [47:0] alloc_mem [ALLOC_N];
  logic [ALLOC_N-1:0] alloc_vld;
  logic [47:0] row_data;
  logic        row_vld;

  // Step payload.
  logic [46:0] dt32;
  s32_t        alt, vx, vy, vz, rate_p, rate_q, rate_r;

  // Working registers.
  s32_t        top, fd, td;
  s64_t        acc, tmp, ge, prod;
  logic [32:0] alpha;
  s64_t        alloc_sum [4];
  s32_t        res [6];

  // Multiplier and divider registers.
  logic [63:0]  ua;
  logic [47:0]  ub;
  logic         neg;
  logic [111:0] pacc;
  logic [64:0]  dr;
  logic [63:0]  dden;
  logic [31:0]  dq;

  // Input field views.
  logic [1:0]  in_op;
  logic [6:0]  in_idx;
  logic signed [47:0] in_val;
  logic        in_acc;

  assign in_op  = s_axis_tuser;
  assign in_idx = s_axis_tdata[6:0];
  assign in_val = s_axis_tdata[54:7];
  assign s_axis_tready = (state == S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Current rotor reads.
  logic [RIW-1:0] ri;
  s32_t        thr_i, drg_i;
  logic [15:0] sig_i;

  assign ri    = cnt[RIW-1:0];
  assign thr_i = thr[ri];
  assign drg_i = drg[ri];
  assign sig_i = sig[ri];

  // Coefficient read address, chosen by the step being worked on.
  logic [3:0] coef_addr;
  s64_t       coef64;

  always_comb begin
    coef_addr = C_THR_S2;
    priority if (state == S_OPND) begin
      priority if (pc == PC_T1) coef_addr = C_THR_S1;
      else if (pc == PC_D2) coef_addr = C_DRG_S2;
      else if (pc == PC_D1) coef_addr = C_DRG_S1;
      else if (pc >= PC_DX && pc <= PC_DZ) coef_addr = C_LIN_MU;
      else if (pc >= PC_DL) coef_addr = C_ANG_MU;
      else coef_addr = C_THR_S2;
    end else if (state == S_POST) begin
      priority if (pc == PC_T1) coef_addr = C_THR_S0;
      else if (pc == PC_D1) coef_addr = C_DRG_S0;
      else coef_addr = 4'(pc - 5'd7);
    end else if (state == S_DEN) begin
      coef_addr = (fd > thr_i) ? C_TAU_UP : C_TAU_DN;
    end else if (state == S_GEINIT) begin
      coef_addr = C_GE_Z4;
    end else begin
      coef_addr = C_THR_S2;
    end
  end

  assign coef64 = s64_t'(coef[coef_addr]);

  // Allocation row read address for the current rotor and step.
  logic [6:0]    rd_full;
  logic [AW-1:0] mem_raddr;
  logic [6:0]    wr_full;

  assign rd_full   = 7'(cnt) * 7'd7 + 7'(pc) - 7'(PC_AT0);
  assign mem_raddr = rd_full[AW-1:0];
  assign wr_full   = in_idx - 7'(COEF_N);

  // Multiplier operands for the current step.
  s64_t row64;
  s64_t op_a;
  logic signed [33:0] op_b;
  logic [32:0] one_minus;

  assign row64 = row_vld ? s64_t'($signed(row_data)) : '0;
  assign one_minus = ONE_Q32 - alpha;

  always_comb begin
    op_a = coef64;
    op_b = $signed({18'd0, sig_i});
    priority if (pc == PC_T2S || pc == PC_D2S) begin
      op_a = tmp;
    end else if (pc == PC_LT_OLD) begin
      op_a = s64_t'(thr_i);
      op_b = $signed({1'b0, one_minus});
    end else if (pc == PC_LT_NEW) begin
      op_a = s64_t'(fd);
      op_b = $signed({1'b0, alpha});
    end else if (pc == PC_LD_OLD) begin
      op_a = s64_t'(drg_i);
      op_b = $signed({1'b0, one_minus});
    end else if (pc == PC_LD_NEW) begin
      op_a = s64_t'(td);
      op_b = $signed({1'b0, alpha});
    end else if (pc >= PC_AT0 && pc < PC_AD0) begin
      op_a = row64;
      op_b = 34'(thr_i);
    end else if (pc >= PC_AD0 && pc <= PC_AD2) begin
      op_a = row64;
      op_b = 34'(drg_i);
    end else if (pc >= PC_GE0 && pc <= PC_GE3) begin
      op_a = acc;
      op_b = 34'(alt);
    end else if (pc == PC_DX) begin
      op_b = 34'(vx);
    end else if (pc == PC_DY) begin
      op_b = 34'(vy);
    end else if (pc == PC_DZ) begin
      op_b = 34'(vz);
    end else if (pc == PC_DL) begin
      op_b = 34'(rate_p);
    end else if (pc == PC_LAST - 5'd1) begin
      op_b = 34'(rate_q);
    end else if (pc == PC_LAST) begin
      op_b = 34'(rate_r);
    end else begin
      op_a = coef64;
    end
  end

  // Shared multiplier pass: one 16-bit slice of the magnitude per cycle.
  logic [79:0] pp;
  logic [33:0] mag_b;

  assign pp    = ua * ub[47:32];
  assign mag_b = op_b[33] ? 34'(-op_b) : 34'(op_b);

  // Saturation of the finished magnitude product.
  s64_t prod_sat;
  always_comb begin
    if (|pacc[111:63]) begin
      prod_sat = neg ? S64_MIN : S64_MAX;
    end else begin
      prod_sat = neg ? -$signed(pacc[63:0]) : $signed(pacc[63:0]);
    end
  end

  // Update arithmetic for the post step.
  s64_t sum_ap, poly_sum, lag_sum, shr32, shr16, ge_sum, ge_fin;
  s32_t lag_v, lag_c;
  logic [1:0] ai;

  assign sum_ap   = sat_add(acc, prod);
  assign poly_sum = sat_add(sum_ap, coef64);
  assign lag_sum  = sum_ap;
  assign lag_v    = sat32(lag_sum >>> 32);
  assign shr32    = prod >>> 32;
  assign shr16    = prod >>> 16;
  assign ge_sum   = sat_add(shr16, coef64);
  assign ge_fin   = ge_sum >>> 16;
  assign ai       = (pc < PC_AD0) ? 2'(pc - PC_AT0) : 2'(pc - PC_AD0);

  always_comb begin
    if (lag_v > top) begin
      lag_c = top;
    end else if (lag_v < 0) begin
      lag_c = '0;
    end else begin
      lag_c = lag_v;
    end
  end

  // Lag denominator and the restoring division step.
  s64_t den;
  logic [64:0] dr2;
  logic        dfit;
  logic [31:0] dq_next;

  assign den     = sat_add(coef64, s64_t'({17'd0, dt32}));
  assign dr2     = {dr[63:0], 1'b0};
  assign dfit    = dr2 >= {1'b0, dden};
  assign dq_next = {dq[30:0], dfit};

  // Signal word clamp to 0..65535.
  logic [15:0] sig_clamped;
  always_comb begin
    if (in_val < 0) begin
      sig_clamped = '0;
    end else if (in_val > 48'sd65535) begin
      sig_clamped = 16'hFFFF;
    end else begin
      sig_clamped = in_val[15:0];
    end
  end

  // Allocation store: written by load words, read one row a cycle.
  logic mem_we;
  assign mem_we = in_acc && (in_op == OP_LOAD) && (in_idx >= 7'(COEF_N))
                  && ({1'b0, in_idx} < 8'(LOAD_TOP));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      alloc_mem[wr_full[AW-1:0]] <= in_val;
    end
    row_data <= alloc_mem[mem_raddr];
  end

  // Main sequencer, rotor state and stores.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pc            <= PC_T2;
      cnt           <= '0;
      nrot          <= '0;
      chunk         <= '0;
      dcnt          <= '0;
      rotor_count   <= ROTOR_COUNT_RESET;
      alloc_vld     <= '0;
      row_vld       <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int k = 0; k < MAX_ROTORS; k++) begin
        sig[k] <= SIG_RESET;
        thr[k] <= '0;
        drg[k] <= '0;
      end
      for (int k = 0; k < COEF_N; k++) begin
        coef[k] <= '0;
      end
    end else begin
      row_vld <= alloc_vld[mem_raddr];
      if (cfg_we) begin
        rotor_count <= cfg_wdata;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (mem_we) begin
        alloc_vld[wr_full[AW-1:0]] <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            priority if (in_op == OP_SIGNAL) begin
              if (in_idx < 7'(MAX_ROTORS)) begin
                sig[in_idx[RIW-1:0]] <= sig_clamped;
              end
            end else if (in_op == OP_LOAD) begin
              if (in_idx < 7'(COEF_N)) begin
                coef[in_idx[3:0]] <= in_val;
              end
            end else if (in_op == OP_STEP) begin
              dt32   <= {s_axis_tdata[85:55], 16'd0};
              alt    <= s_axis_tdata[117:86];
              vx     <= s_axis_tdata[149:118];
              vy     <= s_axis_tdata[181:150];
              vz     <= s_axis_tdata[213:182];
              rate_p <= s_axis_tdata[245:214];
              rate_q <= s_axis_tdata[277:246];
              rate_r <= s_axis_tdata[309:278];
              state  <= S_INIT;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        S_INIT: begin
          top <= coef[C_MAX_THR][47:16];
          for (int k = 0; k < 4; k++) begin
            alloc_sum[k] <= '0;
          end
          cnt <= '0;
          pc  <= PC_T2;
          if ({1'b0, rotor_count} > 5'(MAX_ROTORS)) begin
            nrot  <= 5'(MAX_ROTORS);
            state <= S_ROT;
          end else begin
            nrot  <= {1'b0, rotor_count};
            state <= (rotor_count == 4'd0) ? S_GEINIT : S_ROT;
          end
        end

        // Row read settles in this cycle.
        S_ROT: begin
          state <= S_OPND;
        end

        S_OPND: begin
          ua    <= op_a[63] ? 64'(-op_a) : 64'(op_a);
          ub    <= {14'd0, mag_b};
          neg   <= op_a[63] ^ op_b[33];
          pacc  <= '0;
          chunk <= '0;
          state <= S_MUL;
        end

        S_MUL: begin
          pacc  <= (pacc << 16) + {32'd0, pp};
          ub    <= ub << 16;
          chunk <= chunk + 2'd1;
          if (chunk == 2'd2) begin
            state <= S_SAT;
          end
        end

        S_SAT: begin
          prod  <= prod_sat;
          state <= S_POST;
        end

        S_POST: begin
          pc    <= pc + 5'd1;
          state <= S_ROT;
          priority if (pc == PC_T2 || pc == PC_D2) begin
            tmp <= prod;
          end else if (pc == PC_T2S || pc == PC_D2S || pc == PC_LT_OLD
                       || pc == PC_LD_OLD) begin
            acc <= prod;
          end else if (pc == PC_T1) begin
            fd <= sat32(poly_sum >>> 16);
          end else if (pc == PC_D1) begin
            td    <= sat32(poly_sum >>> 16);
            state <= S_DEN;
          end else if (pc == PC_LT_NEW) begin
            thr[ri] <= lag_c;
          end else if (pc == PC_LD_NEW) begin
            drg[ri] <= lag_c;
          end else if (pc >= PC_AT0 && pc <= PC_AD2) begin
            alloc_sum[ai] <= sat_add(alloc_sum[ai], shr32);
            if (pc == PC_AD2) begin
              if (cnt + 5'd1 < nrot) begin
                cnt <= cnt + 5'd1;
                pc  <= PC_T2;
              end else begin
                state <= S_GEINIT;
              end
            end
          end else if (pc >= PC_GE0 && pc < PC_GE3) begin
            acc <= ge_sum;
          end else if (pc == PC_GE3) begin
            ge <= ge_fin[63] ? '0 : ge_fin;
          end else if (pc == PC_DX || pc == PC_DY) begin
            res[3'(pc - PC_DX)] <= sat32(-shr32);
          end else if (pc == PC_DZ) begin
            res[2] <= sat32(sat_add(sat_add(-shr32, -ge), alloc_sum[3]));
          end else begin
            res[3'(pc - PC_DL) + 3'd3] <=
              sat32(sat_add(-shr32, alloc_sum[2'(pc - PC_DL)]));
            if (pc == PC_LAST) begin
              state <= S_OUT;
            end
          end
        end

        // Pick the lag time constant and set up the division, or set alpha to one if den <= 0 or dt >= den.
        S_DEN: begin
          pc    <= PC_LT_OLD;
          if (den <= 0 || s64_t'({17'd0, dt32}) >= den) begin
            alpha <= ONE_Q32;
            state <= S_ROT;
          end else begin
            dr    <= {18'd0, dt32};
            dden  <= den;
            dq    <= '0;
            dcnt  <= '0;
            state <= S_DIV;
          end
        end

        // One quotient bit per cycle.
        S_DIV: begin
          dr   <= dfit ? (dr2 - {1'b0, dden}) : dr2;
          dq   <= dq_next;
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd31) begin
            alpha <= {1'b0, dq_next};
            state <= S_ROT;
          end
        end

        S_GEINIT: begin
          acc   <= coef64;
          pc    <= PC_GE0;
          state <= S_ROT;
        end

        // Hand the result to the output register once it is free.
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {res[5], res[4], res[3], res[2], res[1], res[0]};
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Division remainder always stays below the divisor.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (dr < {1'b0, dden}))
    else $error("lag division remainder out of range");

  // A step word always starts the sequencer.
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_op == OP_STEP) |=> (state == S_INIT))
    else $error("step word did not start a step");

  // A new result only appears from the hand-off state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == S_OUT))
    else $error("result raised outside hand-off");

endmodule
